// File: hdl/core_count_load_governor_unit_macros.svh
// Assertion macros shared by the governor RTL.
`ifndef CORE_COUNT_LOAD_GOVERNOR_UNIT_MACROS_SVH
`define CORE_COUNT_LOAD_GOVERNOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// A condition that must hold at every clock edge outside reset.
`define CCLG_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// A condition that must hold in the cycle after a trigger.
`define CCLG_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define CCLG_ASSERT_HOLD(lbl, cond, msg)
`define CCLG_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: hdl/cclg_pkg.sv
`timescale 1ns / 1ps
package cclg_pkg;

  // Core table geometry.
  localparam int NUM_CORES = 64;
  localparam int CORE_W    = 6;
  localparam int CNT_W     = 7;

  // Load thresholds and divisor of the core limits.
  localparam int INC_MARGIN  = 80;
  localparam int DEC_MARGIN  = 40;
  localparam int PERCENT     = 100;
  localparam int MIN_DIVISOR = 4;

  // Configuration register indexes.
  localparam logic [1:0] REG_ENABLED = 2'd0;
  localparam logic [1:0] REG_CPU_CAP = 2'd1;
  localparam logic [1:0] REG_POLICY  = 2'd2;

  // Policy codes.
  localparam logic [2:0] POL_DEFAULT      = 3'd0;
  localparam logic [2:0] POL_PERFORMANCE  = 3'd1;
  localparam logic [2:0] POL_POWERSAVE    = 3'd2;
  localparam logic [2:0] POL_ONDEMAND     = 3'd3;
  localparam logic [2:0] POL_CONSERVATIVE = 3'd4;

  // Request kinds.
  localparam logic KIND_BUSY = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_UP   = 2'd1,
    ACT_DOWN = 2'd2
  } action_t;

endpackage

// File: hdl/core_count_load_governor_unit.sv
`timescale 1ns / 1ps
// Core-count load governor.
// Input channel (in_valid/in_ready): a busy report (kind 0) writes the busy
// time of one core into a 64-entry table and gives no result; a tick
// (kind 1) gives exactly one result on the output channel
// (out_valid/out_ready) with action, target_core, load_percent, load_valid.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; index 0 enabled, 1 cpu_cap, 2 policy, other indexes are ignored.
// A busy report is taken in the idle state. A tick that is disabled or not
// running goes straight to its final step; a full tick runs a scan of the
// table (one memory read a cycle, pipelined by one), delta arithmetic and a
// 13-step shift-subtract divider.
// The block is not ready for a new request while a tick is in work.
// The result sits in an output register; a stalled receiver holds it there,
// and the next tick waits in its final step until that register is free.
// Reset is synchronous and clears the table valid bits, time history,
// streak counters and registers (enabled 0, cpu_cap 64, policy 0).
module core_count_load_governor_unit
  import cclg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 kind,
  input  logic [CORE_W-1:0]    core_index,
  input  logic [63:0]          busy_total,
  input  logic [63:0]          wall_now,
  input  logic [63:0]          idle_now,
  input  logic [63:0]          online_mask,
  input  logic                 sys_active,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           action,
  output logic [CORE_W-1:0]    target_core,
  output logic [12:0]          load_percent,
  output logic                 load_valid,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [6:0]           cfg_data
);

`include "core_count_load_governor_unit_macros.svh"

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_CHECK, ST_DELTA, ST_MUL, ST_SUM, ST_NUM,
    ST_DINIT, ST_DIV, ST_STREAK, ST_FINAL
  } state_t;

  state_t state;

  // Configuration registers.
  logic            enabled;
  logic [6:0]      cpu_cap;
  logic [2:0]      policy;

  // Persistent state.
  logic [63:0]     last_wall;
  logic [63:0]     last_idle;
  logic [1:0]      low_streak;
  logic [1:0]      high_streak;
  logic [63:0]     busy_mem [NUM_CORES];
  logic [NUM_CORES-1:0] busy_vld;

  // Per-tick working registers.
  logic [63:0]     mask_r;
  logic [31:0]     wall_r;
  logic [31:0]     idle_r;
  logic [63:0]     wall_full;
  logic [63:0]     idle_full;
  logic [CNT_W-1:0] scan_i;
  logic            p_vld;
  logic [CORE_W-1:0] p_idx;
  logic [63:0]     rd_data;
  logic            rd_vld;
  logic [CNT_W-1:0] cnt;
  logic            up_found;
  logic [CORE_W-1:0] up_core;
  logic [63:0]     best_val;
  logic [CORE_W-1:0] best_core;
  logic [31:0]     wall_d;
  logic [31:0]     idle_d;
  logic [38:0]     prod;
  logic [38:0]     diff;
  logic            wok;
  logic [45:0]     numer;
  logic [32:0]     rem;
  logic [3:0]      dcnt;
  logic [12:0]     quot;
  action_t         act;
  logic            load_v;

  // Output registers.
  action_t         out_act;
  logic [CORE_W-1:0] out_tgt;
  logic [12:0]     out_load;
  logic            out_lv;

  // Core limits and streak limits follow from the registers.
  logic [CNT_W-1:0] max_base, min_base, maxc, minc;
  logic [1:0]       inc_req, dec_req;

  always_comb begin
    max_base = (cpu_cap > CNT_W'(NUM_CORES)) ? CNT_W'(NUM_CORES) : cpu_cap;
    min_base = max_base / CNT_W'(MIN_DIVISOR);
    maxc     = max_base;
    minc     = min_base;
    inc_req  = 2'd1;
    dec_req  = 2'd2;
    case (policy)
      POL_PERFORMANCE:  minc = max_base;
      POL_POWERSAVE:    maxc = min_base;
      POL_ONDEMAND:     inc_req = 2'd0;
      POL_CONSERVATIVE: dec_req = 2'd3;
      default: ;
    endcase
  end

  // Scan element: table value of an online core with a valid entry, else zero.
  logic            p_on;
  logic [63:0]     p_val;

  assign p_on  = mask_r[p_idx];
  assign p_val = (p_on && rd_vld) ? rd_data : 64'd0;

  // Load arithmetic feeding the sum step.
  logic [38:0]     cap_w;
  logic [38:0]     idle_tot;

  assign cap_w    = 39'(wall_d) * 39'(NUM_CORES);
  assign idle_tot = 39'(idle_d) + prod;

  // One divider step.
  logic [33:0]     div_t;
  logic            div_ge;

  assign div_t  = {rem, numer[dcnt]};
  assign div_ge = div_t >= {2'b00, wall_d};

  // Thresholds relative to one core below the online count.
  logic signed [15:0] thr_lo, thr_hi, load_s;

  assign thr_lo = $signed({9'd0, cnt}) * 16'sd100 - 16'(PERCENT + DEC_MARGIN);
  assign thr_hi = $signed({9'd0, cnt}) * 16'sd100 - 16'(PERCENT - INC_MARGIN);
  assign load_s = $signed({3'd0, quot});

  // Final choice of core.
  action_t         fin_act;
  logic [CORE_W-1:0] fin_tgt;

  always_comb begin
    fin_act = ACT_NONE;
    fin_tgt = '0;
    case (act)
      ACT_UP: begin
        if (cnt != maxc && up_found) begin
          fin_act = ACT_UP;
          fin_tgt = up_core;
        end
      end
      ACT_DOWN: begin
        if (cnt != minc && best_core != '0) begin
          fin_act = ACT_DOWN;
          fin_tgt = best_core;
        end
      end
      default: ;
    endcase
  end

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign action       = out_act;
  assign target_core  = out_tgt;
  assign load_percent = out_load;
  assign load_valid   = out_lv;

  // Busy table memory with registered read.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && kind == KIND_BUSY) begin
      busy_mem[core_index] <= busy_total;
    end
    rd_data <= busy_mem[scan_i[CORE_W-1:0]];
    rd_vld  <= busy_vld[scan_i[CORE_W-1:0]];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      cpu_cap <= 7'd64;
      policy  <= POL_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLED: enabled <= cfg_data[0];
        REG_CPU_CAP: cpu_cap <= cfg_data;
        REG_POLICY:  policy  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Sequencer and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      busy_vld    <= '0;
      last_wall   <= '0;
      last_idle   <= '0;
      low_streak  <= '0;
      high_streak <= '0;
      out_valid   <= 1'b0;
      p_vld       <= 1'b0;
    end else begin
      // The final step loads the output register itself.
      if (out_valid && out_ready && state != ST_FINAL) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (kind == KIND_BUSY) begin
              busy_vld[core_index] <= 1'b1;
            end else begin
              mask_r    <= online_mask;
              wall_full <= wall_now;
              idle_full <= idle_now;
              wall_r    <= wall_now[31:0];
              idle_r    <= idle_now[31:0];
              act       <= ACT_NONE;
              load_v    <= 1'b0;
              cnt       <= '0;
              up_found  <= 1'b0;
              up_core   <= '0;
              scan_i    <= '0;
              p_vld     <= 1'b0;
              state     <= (enabled && sys_active) ? ST_SCAN : ST_FINAL;
            end
          end
        end
        ST_SCAN: begin
          // Issue one read a cycle and fold in the previous one.
          if (scan_i != CNT_W'(NUM_CORES)) begin
            p_idx  <= scan_i[CORE_W-1:0];
            scan_i <= scan_i + 1'b1;
          end
          p_vld <= (scan_i != CNT_W'(NUM_CORES));
          if (p_vld) begin
            if (p_on) begin
              cnt <= cnt + 1'b1;
            end
            if (p_idx != '0 && !p_on && !up_found) begin
              up_found <= 1'b1;
              up_core  <= p_idx;
            end
            if (p_idx == '0) begin
              best_val  <= p_val;
              best_core <= '0;
            end else if (p_val != '0 && p_val < best_val) begin
              best_val  <= p_val;
              best_core <= p_idx;
            end
          end
          if (scan_i == CNT_W'(NUM_CORES) && !p_vld) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (cnt > maxc) begin
            act   <= ACT_DOWN;
            state <= ST_FINAL;
          end else if (cnt < minc) begin
            act   <= ACT_UP;
            state <= ST_FINAL;
          end else begin
            state <= ST_DELTA;
          end
        end
        ST_DELTA: begin
          wall_d    <= wall_r - last_wall[31:0];
          idle_d    <= idle_r - last_idle[31:0];
          last_wall <= wall_full;
          last_idle <= idle_full;
          state     <= ST_MUL;
        end
        ST_MUL: begin
          prod  <= 39'(wall_d) * 39'(CNT_W'(NUM_CORES) - cnt);
          state <= ST_SUM;
        end
        ST_SUM: begin
          wok   <= (wall_d != '0) && (cap_w >= idle_tot);
          diff  <= cap_w - idle_tot;
          state <= ST_NUM;
        end
        ST_NUM: begin
          numer <= 46'(diff) * 46'(PERCENT);
          state <= wok ? ST_DINIT : ST_FINAL;
        end
        ST_DINIT: begin
          // The quotient stays below 2^13, so the top bits start the remainder.
          rem   <= numer[45:13];
          dcnt  <= 4'd12;
          quot  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem  <= div_ge ? 33'(div_t - {2'b00, wall_d}) : div_t[32:0];
          quot <= {quot[11:0], div_ge};
          if (dcnt == '0) begin
            state <= ST_STREAK;
          end else begin
            dcnt <= dcnt - 1'b1;
          end
        end
        ST_STREAK: begin
          load_v <= 1'b1;
          if (load_s < thr_lo) begin
            high_streak <= '0;
            if (low_streak < dec_req) begin
              low_streak <= low_streak + 1'b1;
            end else begin
              low_streak <= '0;
              act        <= ACT_DOWN;
            end
          end else begin
            low_streak <= '0;
            if (load_s > thr_hi) begin
              if (high_streak < inc_req) begin
                high_streak <= high_streak + 1'b1;
              end else begin
                high_streak <= '0;
                act         <= ACT_UP;
              end
            end
          end
          state <= ST_FINAL;
        end
        ST_FINAL: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_act   <= fin_act;
            out_tgt   <= fin_tgt;
            out_load  <= load_v ? quot : '0;
            out_lv    <= load_v;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `CCLG_ASSERT_HOLD(a_tgt_zero, !out_valid || out_act != ACT_NONE || out_tgt == '0, "target without action")
  `CCLG_ASSERT_HOLD(a_load_zero, !out_valid || out_lv || out_load == '0, "load without valid")
  `CCLG_ASSERT_HOLD(a_rem_bound, state != ST_DIV || rem < 33'(wall_d), "divider remainder out of range")
  `CCLG_ASSERT_NEXT(a_tick_busy, in_valid && in_ready && kind == KIND_TICK, !in_ready, "tick not taken")

endmodule
